>>> hw/rtl/vplt_pkg.sv
package vplt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TIME_W     = 63;
  localparam int GRID_W     = 64;
  localparam int PER_W      = 48;
  localparam int NUM_W      = 80;
  localparam int DEN_W      = 54;
  localparam int QUOT_W     = 54;
  localparam int LEN_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LEN_W-1:0] DIV_LEN_SHORT = 7'd54;
  localparam logic [LEN_W-1:0] DIV_LEN_SNAP  = 7'd80;

  localparam logic [1:0] OP_PRESENT = 2'd0;
  localparam logic [1:0] OP_RESET   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESYNC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PH_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PR_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_FRAC  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_FLOOR = 3'd6;

  localparam logic [29:0] NOMINAL_RST   = 30'd16666667;
  localparam logic [31:0] RESYNC_RST    = 32'd250000000;
  localparam logic [15:0] PH_GAIN_RST   = 16'd6554;
  localparam logic [15:0] PR_GAIN_RST   = 16'd655;
  localparam logic [15:0] TOL_RST       = 16'd3277;
  localparam logic [15:0] WIN_FRAC_RST  = 16'd3277;
  localparam logic [26:0] WIN_FLOOR_RST = 27'd1000000;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TIME_W-1:0] time_ns;
  } in_item_t;

  typedef struct packed {
    logic              locked;
    logic [7:0]        lock_score;
    logic [30:0]       period_ns;
    logic [TIME_W-1:0] grid_ns;
    logic              resynced;
  } out_item_t;

  typedef enum logic [4:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_CLASS,
    STEP_MUL_NT,
    STEP_BOUNDS,
    STEP_DIV1,
    STEP_ERR,
    STEP_MUL_PH,
    STEP_GRID,
    STEP_MUL_PR,
    STEP_DIV2,
    STEP_PERIOD,
    STEP_MUL_WIN,
    STEP_SCORE,
    STEP_SNAP,
    STEP_SNAP_E,
    STEP_OUT
  } step_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLASS,
    ST_MUL_NT,
    ST_BOUNDS,
    ST_DIV1,
    ST_DIV1_WAIT,
    ST_ERR,
    ST_MUL_PH,
    ST_GRID,
    ST_MUL_PR,
    ST_DIV2,
    ST_DIV2_WAIT,
    ST_PERIOD,
    ST_MUL_WIN,
    ST_SCORE,
    ST_SNAP,
    ST_SNAP_WAIT,
    ST_SNAP_E,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic track;
    logic n_zero;
    logic div_busy;
  } status_t;

endpackage

>>> hw/rtl/vsync_phase_lock_tracker_top.sv
// A query, a reset, or a present that restarts the grid, is disabled or lies at or
// before the grid goes straight to the snap; a present that rounds to the current
// refresh skips the grid and period update; a tracked present runs every step. A
// finished result waits in the last step while the output register is still full.
// One transaction at a time, with one shared divider (one quotient bit per cycle: 54
// bits for a count, 80 for a snap); the next is accepted while a result waits.
module vsync_phase_lock_tracker_top #(
  parameter int LOCK_COUNT   = 8,
  parameter int MISS_PENALTY = 3,
  parameter int RELOCK_COUNT = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  vplt_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output vplt_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [vplt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vplt_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import vplt_pkg::*;

  // Reset is asynchronous and active low; registers and tracker state take defaults.

  step_e   step;
  status_t status;

  vplt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .step_o      (step)
  );

  vplt_dp #(
    .LOCK_COUNT   (LOCK_COUNT),
    .MISS_PENALTY (MISS_PENALTY),
    .RELOCK_COUNT (RELOCK_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while one is in progress");

  a_locked_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.locked |-> out_data_o.lock_score >= 8'(RELOCK_COUNT))
    else $error("locked with score below relock level");

  a_resync_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.resynced |->
      !out_data_o.locked && out_data_o.lock_score == 8'd0)
    else $error("resync did not clear lock state");

  a_score_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.lock_score <= 8'(LOCK_COUNT))
    else $error("lock score above lock count");

endmodule

>>> hw/rtl/vplt_div.sv
module vplt_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [vplt_pkg::NUM_W-1:0]   num_i,
  input  logic [vplt_pkg::DEN_W-1:0]   den_i,
  input  logic [vplt_pkg::LEN_W-1:0]   len_i,
  output logic                         busy_o,
  output logic [vplt_pkg::NUM_W-1:0]   quot_o,
  output logic [vplt_pkg::DEN_W-1:0]   rem_o
);
  import vplt_pkg::*;

  logic [NUM_W-1:0] q_q;
  logic [DEN_W-1:0] r_q, den_q, r_d;
  logic [LEN_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   r2, rsub;
  logic             ge;

  // Restoring division, one quotient bit per cycle. The numerator is
  // left-aligned so that only len_i bits are processed.
  assign r2   = {r_q, q_q[NUM_W-1]};
  assign rsub = r2 - {1'b0, den_q};
  assign ge   = r2 >= {1'b0, den_q};
  assign r_d  = ge ? rsub[DEN_W-1:0] : r2[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= len_i != '0;
      cnt_q  <= len_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == LEN_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q <= {q_q[NUM_W-2:0], ge};
      r_q <= r_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

>>> hw/rtl/vplt_dp.sv
module vplt_dp #(
  parameter int LOCK_COUNT   = 8,
  parameter int MISS_PENALTY = 3,
  parameter int RELOCK_COUNT = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vplt_pkg::in_item_t                in_data_i,
  input  logic                              cfg_we_i,
  input  logic [vplt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vplt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  vplt_pkg::step_e                   step_i,
  output vplt_pkg::status_t                 status_o,
  output vplt_pkg::out_item_t               out_data_o
);
  import vplt_pkg::*;

  localparam logic [7:0] LockCnt   = 8'(LOCK_COUNT);
  localparam logic [7:0] MissPen   = 8'(MISS_PENALTY);
  localparam logic [7:0] RelockCnt = 8'(RELOCK_COUNT);
  localparam logic [64:0] Rnd      = 65'(1) << (FRAC_BITS - 1);
  localparam int Pad               = NUM_W - QUOT_W;

  // Configuration
  logic [29:0] nom_q;
  logic [31:0] thr_q;
  logic [15:0] phg_q, prg_q, tol_q, wfr_q;
  logic [26:0] wfl_q;

  // Tracker state
  logic [GRID_W-1:0]    gw_q;
  logic [FRAC_BITS-1:0] gf_q;
  logic [PER_W-1:0]     per_q;
  logic [TIME_W-1:0]    last_q;
  logic                 seen_q, lock_q;
  logic [7:0]           score_q;

  // Per-transaction working registers
  logic [1:0]        op_q;
  logic [TIME_W-1:0] t_q;
  logic [51:0]       d_q;
  logic [QUOT_W-1:0] n_q;
  logic              neg_q, rs_q, snap_gt_q, e_pos_q;
  logic [PER_W-1:0]  mag_q, lo_q, hi_q, e_mag_q;
  logic [63:0]       prod_q;
  out_item_t         out_q;

  // Divider hookup
  logic              div_start, div_busy;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic [DEN_W-1:0]  div_den, div_rem;
  logic [LEN_W-1:0]  div_len;

  // Shared multiplier
  logic [PER_W-1:0] mul_a;
  logic [15:0]      mul_b;

  logic [GRID_W-1:0] t_w, dw;
  logic [NUM_W-1:0]  t_fix, g_fix, d_full, g_minus_t, grid_new;
  logic [TIME_W-1:0] gap_diff;
  logic              gt, gap, far, is_present, dis, first;
  logic              cls_resync, cls_same, cls_track;
  logic [64:0]       prod_rnd;
  logic [PER_W-1:0]  rnd;
  logic [QUOT_W-1:0] num1, num2, p54, err_abs;
  logic              r_lt_p, n_zero;
  logic [PER_W-1:0]  nomf, lo_raw, lo_eff, hi_new;
  logic [54:0]       per_raw;
  logic              per_lo, per_hi;
  logic [PER_W-1:0]  per_new, floor_f, win;
  logic              hit;
  logic [7:0]        sc_new;
  logic              lk_new;
  logic [PER_W-1:0]  r48, pmr;
  logic              half, e_pos_d;
  logic [PER_W-1:0]  e_mag_d;
  logic [31:0]       ew;
  logic [15:0]       ef;
  logic              fz, no_grid;
  logic [63:0]       wsum;
  logic [64:0]       wdiff;
  logic [TIME_W-1:0] snap_res;
  logic [PER_W:0]    per_rnd;

  // Classification of a present against the current grid
  assign t_w        = {1'b0, t_q};
  assign t_fix      = {1'b0, t_q, {FRAC_BITS{1'b0}}};
  assign g_fix      = {gw_q, gf_q};
  assign gt         = t_w > gw_q;
  assign d_full     = t_fix - g_fix;
  assign g_minus_t  = g_fix - t_fix;
  assign gap_diff   = t_q - last_q;
  assign gap        = (t_q > last_q) && (gap_diff > {31'b0, thr_q});
  assign dw         = t_w - gw_q;
  assign far        = |dw[GRID_W-1:36];
  assign is_present = op_q == OP_PRESENT;
  assign dis        = (nom_q == '0) || (per_q == '0);
  assign first      = !seen_q || gap;
  assign cls_resync = is_present && !dis && (first || (gt && far));
  assign cls_same   = is_present && !dis && !first && !gt;
  assign cls_track  = is_present && !dis && !first && gt && !far;

  // Rounded Q0.16 product
  assign prod_rnd = {1'b0, prod_q} + Rnd;
  assign rnd      = prod_rnd[FRAC_BITS +: PER_W];

  // Refresh count n = round(d / p) is the quotient of (2d + p) / 2p. The
  // remainder r gives the phase error directly as (r - p) / 2.
  assign num1    = {1'b0, d_q, 1'b0} + {6'b0, per_q};
  assign num2    = {5'b0, rnd, 1'b0} + n_q;
  assign p54     = {6'b0, per_q};
  assign r_lt_p  = div_rem < p54;
  assign err_abs = r_lt_p ? p54 - div_rem : div_rem - p54;
  assign n_zero  = div_quot[QUOT_W-1:0] == '0;

  // The old grid plus d is exactly the present time.
  assign grid_new = neg_q ? t_fix + {32'b0, mag_q} - {32'b0, rnd}
                          : t_fix - {32'b0, mag_q} + {32'b0, rnd};

  assign nomf   = {2'b0, nom_q, {FRAC_BITS{1'b0}}};
  assign lo_raw = nomf - prod_q[PER_W-1:0];
  assign lo_eff = (lo_raw == '0) ? PER_W'(1) : lo_raw;
  assign hi_new = nomf + prod_q[PER_W-1:0];

  assign per_raw = neg_q ? {7'b0, per_q} - {1'b0, div_quot[QUOT_W-1:0]}
                         : {7'b0, per_q} + {1'b0, div_quot[QUOT_W-1:0]};
  assign per_lo  = per_raw[54] || (per_raw < {7'b0, lo_q});
  assign per_hi  = !per_raw[54] && (per_raw > {7'b0, hi_q});
  assign per_new = per_hi ? hi_q : (per_lo ? lo_q : per_raw[PER_W-1:0]);

  assign floor_f = {5'b0, wfl_q, {FRAC_BITS{1'b0}}};
  assign win     = (rnd > floor_f) ? rnd : floor_f;
  assign hit     = mag_q <= win;

  always_comb begin
    if (hit) begin
      sc_new = (score_q < LockCnt) ? score_q + 8'd1 : score_q;
    end else begin
      sc_new = (score_q > MissPen) ? score_q - MissPen : 8'd0;
    end
    if (sc_new >= LockCnt) begin
      lk_new = 1'b1;
    end else if (sc_new < RelockCnt) begin
      lk_new = 1'b0;
    end else begin
      lk_new = lock_q;
    end
  end

  // Signed distance from the time to the nearest grid point
  assign r48     = div_rem[PER_W-1:0];
  assign half    = {r48, 1'b0} >= {1'b0, per_q};
  assign pmr     = per_q - r48;
  assign e_pos_d = snap_gt_q ? (!half && (r48 != '0)) : half;
  assign e_mag_d = half ? pmr : r48;

  assign ew      = e_mag_q[PER_W-1:FRAC_BITS];
  assign ef      = e_mag_q[FRAC_BITS-1:0];
  assign fz      = ef != '0;
  assign no_grid = !seen_q || (per_q == '0);
  assign wsum    = t_w + {32'b0, ew} + {63'b0, e_mag_q[FRAC_BITS-1]};
  assign wdiff   = {2'b0, t_q} - {33'b0, ew} - {64'b0, fz};

  always_comb begin
    if (no_grid) begin
      snap_res = t_q;
    end else if (!e_pos_q) begin
      snap_res = wsum[63] ? {TIME_W{1'b1}} : wsum[TIME_W-1:0];
    end else if (wdiff[64]) begin
      snap_res = '0;
    end else begin
      snap_res = wdiff[TIME_W-1:0] + {62'b0, fz && (ef <= 16'h8000)};
    end
  end

  assign per_rnd = {1'b0, per_q} + Rnd[PER_W:0];

  always_comb begin
    mul_a = mag_q;
    mul_b = prg_q;
    case (step_i)
      STEP_MUL_NT: begin
        mul_a = {18'b0, nom_q};
        mul_b = tol_q;
      end
      STEP_MUL_PH: begin
        mul_b = phg_q;
      end
      STEP_MUL_WIN: begin
        mul_a = per_q;
        mul_b = wfr_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = d_full;
    div_den   = p54;
    div_len   = DIV_LEN_SHORT;
    case (step_i)
      STEP_DIV1: begin
        div_start = 1'b1;
        div_num   = {num1, {Pad{1'b0}}};
        div_den   = {5'b0, per_q, 1'b0};
      end
      STEP_DIV2: begin
        div_start = 1'b1;
        div_num   = {num2, {Pad{1'b0}}};
        div_den   = {n_q[QUOT_W-2:0], 1'b0};
      end
      STEP_SNAP: begin
        div_start = 1'b1;
        div_num   = gt ? d_full : g_minus_t;
        div_len   = DIV_LEN_SNAP;
      end
      default: begin
      end
    endcase
  end

  vplt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .len_i   (div_len),
    .busy_o  (div_busy),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Configuration and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_q   <= NOMINAL_RST;
      thr_q   <= RESYNC_RST;
      phg_q   <= PH_GAIN_RST;
      prg_q   <= PR_GAIN_RST;
      tol_q   <= TOL_RST;
      wfr_q   <= WIN_FRAC_RST;
      wfl_q   <= WIN_FLOOR_RST;
      gw_q    <= '0;
      gf_q    <= '0;
      per_q   <= {2'b0, NOMINAL_RST, {FRAC_BITS{1'b0}}};
      last_q  <= '0;
      seen_q  <= 1'b0;
      score_q <= '0;
      lock_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NOMINAL: begin
          // A new nominal period restarts the tracker.
          nom_q   <= cfg_data_i[29:0];
          gw_q    <= '0;
          gf_q    <= '0;
          per_q   <= {2'b0, cfg_data_i[29:0], {FRAC_BITS{1'b0}}};
          last_q  <= '0;
          seen_q  <= 1'b0;
          score_q <= '0;
          lock_q  <= 1'b0;
        end
        CFG_RESYNC:    thr_q <= cfg_data_i;
        CFG_PH_GAIN:   phg_q <= cfg_data_i[15:0];
        CFG_PR_GAIN:   prg_q <= cfg_data_i[15:0];
        CFG_TOL:       tol_q <= cfg_data_i[15:0];
        CFG_WIN_FRAC:  wfr_q <= cfg_data_i[15:0];
        CFG_WIN_FLOOR: wfl_q <= cfg_data_i[26:0];
        default: begin
        end
      endcase
    end else begin
      case (step_i)
        STEP_CLASS: begin
          if (op_q == OP_RESET) begin
            gw_q    <= '0;
            gf_q    <= '0;
            per_q   <= nomf;
            last_q  <= '0;
            seen_q  <= 1'b0;
            score_q <= '0;
            lock_q  <= 1'b0;
          end else if (cls_resync) begin
            gw_q    <= t_w;
            gf_q    <= '0;
            last_q  <= t_q;
            seen_q  <= 1'b1;
            score_q <= '0;
            lock_q  <= 1'b0;
          end else if (cls_same) begin
            last_q <= t_q;
          end
        end
        STEP_ERR: begin
          // A present that rounds to the current refresh only moves the last time.
          if (n_zero) begin
            last_q <= t_q;
          end
        end
        STEP_GRID: begin
          gw_q <= grid_new[NUM_W-1:FRAC_BITS];
          gf_q <= grid_new[FRAC_BITS-1:0];
        end
        STEP_PERIOD: begin
          per_q <= per_new;
        end
        STEP_SCORE: begin
          score_q <= sc_new;
          lock_q  <= lk_new;
          last_q  <= t_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= 1'b0;
    end else if (step_i == STEP_LOAD) begin
      rs_q <= 1'b0;
    end else if (step_i == STEP_CLASS) begin
      rs_q <= cls_resync && (op_q != OP_RESET);
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (step_i)
      STEP_LOAD: begin
        op_q <= in_data_i.opcode;
        t_q  <= in_data_i.time_ns;
      end
      STEP_CLASS: begin
        d_q <= d_full[51:0];
      end
      STEP_MUL_NT, STEP_MUL_PH, STEP_MUL_PR, STEP_MUL_WIN: begin
        prod_q <= 64'(mul_a * mul_b);
      end
      STEP_BOUNDS: begin
        lo_q <= lo_eff;
        hi_q <= hi_new;
      end
      STEP_ERR: begin
        n_q   <= div_quot[QUOT_W-1:0];
        neg_q <= r_lt_p;
        mag_q <= err_abs[PER_W:1];
      end
      STEP_SNAP: begin
        snap_gt_q <= gt;
      end
      STEP_SNAP_E: begin
        e_pos_q <= e_pos_d;
        e_mag_q <= e_mag_d;
      end
      STEP_OUT: begin
        out_q.locked     <= lock_q;
        out_q.lock_score <= score_q;
        out_q.period_ns  <= per_rnd[FRAC_BITS +: 31];
        out_q.grid_ns    <= snap_res;
        out_q.resynced   <= rs_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.track    = cls_track;
  assign status_o.n_zero   = n_zero;
  assign status_o.div_busy = div_busy;
  assign out_data_o        = out_q;

endmodule

>>> hw/rtl/vplt_ctrl.sv
module vplt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  vplt_pkg::status_t status_i,
  output vplt_pkg::step_e   step_o
);
  import vplt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_CLASS;
      ST_CLASS:     state_d = status_i.track ? ST_MUL_NT : ST_SNAP;
      ST_MUL_NT:    state_d = ST_BOUNDS;
      ST_BOUNDS:    state_d = ST_DIV1;
      ST_DIV1:      state_d = ST_DIV1_WAIT;
      ST_DIV1_WAIT: if (!status_i.div_busy) state_d = ST_ERR;
      ST_ERR:       state_d = status_i.n_zero ? ST_SNAP : ST_MUL_PH;
      ST_MUL_PH:    state_d = ST_GRID;
      ST_GRID:      state_d = ST_MUL_PR;
      ST_MUL_PR:    state_d = ST_DIV2;
      ST_DIV2:      state_d = ST_DIV2_WAIT;
      ST_DIV2_WAIT: if (!status_i.div_busy) state_d = ST_PERIOD;
      ST_PERIOD:    state_d = ST_MUL_WIN;
      ST_MUL_WIN:   state_d = ST_SCORE;
      ST_SCORE:     state_d = ST_SNAP;
      ST_SNAP:      state_d = ST_SNAP_WAIT;
      ST_SNAP_WAIT: if (!status_i.div_busy) state_d = ST_SNAP_E;
      ST_SNAP_E:    state_d = ST_DONE;
      ST_DONE:      if (slot_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    step_o = STEP_NONE;
    case (state_q)
      ST_IDLE:    if (in_valid_i) step_o = STEP_LOAD;
      ST_CLASS:   step_o = STEP_CLASS;
      ST_MUL_NT:  step_o = STEP_MUL_NT;
      ST_BOUNDS:  step_o = STEP_BOUNDS;
      ST_DIV1:    step_o = STEP_DIV1;
      ST_ERR:     step_o = STEP_ERR;
      ST_MUL_PH:  step_o = STEP_MUL_PH;
      ST_GRID:    step_o = STEP_GRID;
      ST_MUL_PR:  step_o = STEP_MUL_PR;
      ST_DIV2:    step_o = STEP_DIV2;
      ST_PERIOD:  step_o = STEP_PERIOD;
      ST_MUL_WIN: step_o = STEP_MUL_WIN;
      ST_SCORE:   step_o = STEP_SCORE;
      ST_SNAP:    step_o = STEP_SNAP;
      ST_SNAP_E:  step_o = STEP_SNAP_E;
      ST_DONE:    if (slot_free) step_o = STEP_OUT;
      default:    step_o = STEP_NONE;
    endcase
  end

  // The result register frees the input side while a result waits.
  assign out_valid_d = (out_valid_q && !out_ready_i) || (state_q == ST_DONE && slot_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

>>> tb/tb_top.sv
module tb_top;
  import vplt_pkg::*;

  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam bit [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] FMASK = 64'hFFFF;
  localparam bit [63:0] FHALF = 64'h8000;
  localparam int unsigned LOCK_CNT = 8;
  localparam int unsigned MISS_PEN = 3;
  localparam int unsigned RELOCK_CNT = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  vsync_phase_lock_tracker_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Tracker copy kept in step with the block.
  bit [63:0] nom_ns, gap_limit_ns, ph_gain, pr_gain, tol, win_frac, win_floor;
  bit [63:0] grid_whole, grid_frac, period_fx, last_present;
  bit present_seen, is_locked;
  int unsigned hit_score;

  in_item_t stimulus_q[$];
  out_item_t expected_results[$];
  int mismatches = 0;
  bit run_go = 1'b0;
  bit no_idle = 1'b0;
  bit in_taken = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  function automatic bit [63:0] mul_gain(bit [63:0] a, bit [63:0] g);
    return ((a >> 16) * g) + ((((a & FMASK) * g) + 64'h8000) >> 16);
  endfunction

  function automatic bit [63:0] shifted_mod(bit [63:0] w, bit [63:0] p);
    bit [63:0] r;
    r = w % p;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      if (r >= p) r = r - p;
    end
    return r;
  endfunction

  function automatic void restart_grid();
    grid_whole = 0;
    grid_frac = 0;
    period_fx = nom_ns << FRAC_BITS;
    last_present = 0;
    present_seen = 0;
    hit_score = 0;
    is_locked = 0;
  endfunction

  function automatic void resync_grid(bit [63:0] t);
    grid_whole = t;
    grid_frac = 0;
    last_present = t;
    present_seen = 1;
    hit_score = 0;
    is_locked = 0;
  endfunction

  function automatic bit [63:0] snap_to_grid(bit [63:0] t);
    bit [63:0] p, rem, a, w, ew, ef;
    longint e;
    p = period_fx;
    if (!present_seen || p == 0) return t;
    if (t > grid_whole) begin
      rem = (shifted_mod(t - grid_whole, p) + p - grid_frac % p) % p;
      e = (2 * rem >= p) ? longint'(rem) - longint'(p) : longint'(rem);
    end else begin
      rem = (shifted_mod(grid_whole - t, p) + grid_frac % p) % p;
      e = (2 * rem >= p) ? longint'(p - rem) : -longint'(rem);
    end
    if (e <= 0) begin
      a = 64'(-e);
      w = t + (a >> FRAC_BITS) + (((a & FMASK) >= FHALF) ? 64'd1 : 64'd0);
      return (w > MAX63) ? MAX63 : w;
    end
    ew = 64'(e) >> FRAC_BITS;
    ef = 64'(e) & FMASK;
    if (ef == 0) return (t >= ew) ? t - ew : 64'd0;
    if (t < ew + 1) return 64'd0;
    return t - ew - 1 + ((((FMASK + 1) - ef) >= FHALF) ? 64'd1 : 64'd0);
  endfunction

  function automatic bit track_present(bit [63:0] t);
    bit [63:0] p, dw, d, n, np, mag, pc, lo, hi, win, floor_f, frac_sum, dlt;
    longint err, delta, per;
    bit neg;
    p = period_fx;
    if (nom_ns == 0 || p == 0) return 0;
    if (!present_seen || (t > last_present && t - last_present > gap_limit_ns)) begin
      resync_grid(t);
      return 1;
    end
    if (t <= grid_whole) begin
      last_present = t;
      return 0;
    end
    dw = t - grid_whole;
    if (dw >= (64'd1 << 36)) begin
      resync_grid(t);
      return 1;
    end
    d = (dw << FRAC_BITS) - grid_frac;
    n = (2 * d + p) / (2 * p);
    if (n < 1) begin
      last_present = t;
      return 0;
    end
    np = n * p;
    err = longint'(d) - longint'(np);
    neg = err < 0;
    mag = neg ? 64'(-err) : 64'(err);
    delta = neg ? longint'(np) - longint'(mul_gain(mag, ph_gain))
                : longint'(np) + longint'(mul_gain(mag, ph_gain));
    dlt = 64'(delta);
    frac_sum = grid_frac + (dlt & FMASK);
    grid_whole = grid_whole + (dlt >> FRAC_BITS) + (frac_sum >> FRAC_BITS);
    grid_frac = frac_sum & FMASK;
    pc = mul_gain(mag, pr_gain);
    pc = (2 * pc + n) / (2 * n);
    per = neg ? longint'(p) - longint'(pc) : longint'(p) + longint'(pc);
    lo = nom_ns * (64'd65536 - tol);
    hi = nom_ns * (64'd65536 + tol);
    if (lo < 1) lo = 1;
    if (per < longint'(lo)) per = longint'(lo);
    if (per > longint'(hi)) per = longint'(hi);
    period_fx = 64'(per);
    win = mul_gain(period_fx, win_frac);
    floor_f = win_floor << FRAC_BITS;
    if (floor_f > win) win = floor_f;
    if (mag <= win) begin
      if (hit_score < LOCK_CNT) hit_score++;
    end else begin
      hit_score = (hit_score > MISS_PEN) ? hit_score - MISS_PEN : 0;
    end
    if (hit_score >= LOCK_CNT) is_locked = 1;
    else if (hit_score < RELOCK_CNT) is_locked = 0;
    last_present = t;
    return 0;
  endfunction

  function automatic out_item_t predict_result(in_item_t item);
    out_item_t r;
    bit [63:0] t;
    bit [63:0] g;
    bit rs;
    t = {1'b0, item.time_ns};
    rs = 0;
    if (item.opcode == OP_PRESENT) rs = track_present(t);
    else if (item.opcode == OP_RESET) restart_grid();
    r.locked = is_locked;
    r.lock_score = hit_score[7:0];
    r.period_ns = 31'((period_fx + FHALF) >> FRAC_BITS);
    g = snap_to_grid(t);
    r.grid_ns = g[62:0];
    r.resynced = rs;
    return r;
  endfunction

  // Register writes, accepted inputs and returned results, all seen at the rising edge.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    in_taken <= in_valid_i && in_ready_o;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NOMINAL: begin
          nom_ns = {34'd0, cfg_data_i[29:0]};
          restart_grid();
        end
        CFG_RESYNC: gap_limit_ns = {32'd0, cfg_data_i};
        CFG_PH_GAIN: ph_gain = {48'd0, cfg_data_i[15:0]};
        CFG_PR_GAIN: pr_gain = {48'd0, cfg_data_i[15:0]};
        CFG_TOL: tol = {48'd0, cfg_data_i[15:0]};
        CFG_WIN_FRAC: win_frac = {48'd0, cfg_data_i[15:0]};
        CFG_WIN_FLOOR: win_floor = {37'd0, cfg_data_i[26:0]};
        default: ;
      endcase
    end
    if (in_valid_i && in_ready_o) expected_results.push_back(predict_result(in_data_i));
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: %p", out_data_o);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data_o.locked !== exp_r.locked) begin
          $error("locked: expected %0d actual %0d", exp_r.locked, out_data_o.locked);
          mismatches++;
        end
        if (out_data_o.lock_score !== exp_r.lock_score) begin
          $error("lock_score: expected %0d actual %0d", exp_r.lock_score,
                 out_data_o.lock_score);
          mismatches++;
        end
        if (out_data_o.period_ns !== exp_r.period_ns) begin
          $error("period_ns: expected %0d actual %0d", exp_r.period_ns,
                 out_data_o.period_ns);
          mismatches++;
        end
        if (out_data_o.grid_ns !== exp_r.grid_ns) begin
          $error("grid_ns: expected %0d actual %0d", exp_r.grid_ns, out_data_o.grid_ns);
          mismatches++;
        end
        if (out_data_o.resynced !== exp_r.resynced) begin
          $error("resynced: expected %0d actual %0d", exp_r.resynced,
                 out_data_o.resynced);
          mismatches++;
        end
      end
    end
  end

  // Sender: a new transaction is offered only once the previous one was taken.
  always @(negedge clk_i) begin
    if (run_go && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        gap_left <= $urandom_range(0, 18);
        in_valid_i <= 1'b0;
      end else if (stimulus_q.size() > 0) begin
        in_data_i <= stimulus_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver with random stall bursts.
  always @(negedge clk_i) begin
    if (!run_go) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (stimulus_q.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (210) @(posedge clk_i);
  endtask

  task automatic add_item(logic [1:0] op, bit [63:0] t);
    in_item_t it;
    it.opcode = op;
    it.time_ns = t[62:0];
    stimulus_q.push_back(it);
  endtask

  // Mostly presents that follow the refresh grid with jitter, plus queries, resets, spare opcodes and noise.
  task automatic add_random_items(int count, bit [63:0] nominal);
    bit [63:0] t_now, step;
    int unsigned span, pick;
    span = (nominal > 64'd16) ? 32'(nominal >> 3) : 32'd2;
    t_now = {$urandom_range(0, 3), $urandom} << $urandom_range(0, 28);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        step = nominal * $urandom_range(1, ($urandom_range(0, 7) == 0) ? 4 : 1);
        if ($urandom_range(0, 9) == 0) step = step + $urandom_range(0, 4 * span);
        else step = step + $urandom_range(0, span) - (span >> 1);
        t_now = t_now + step;
        add_item(OP_PRESENT, t_now);
      end else if (pick < 68) begin
        add_item(OP_PRESENT, t_now + $urandom_range(0, span >> 2));
      end else if (pick < 85) begin
        add_item(OP_QUERY, t_now + $urandom_range(0, 4 * span) - 2 * span);
      end else if (pick < 88) begin
        add_item(OP_RESET, {$urandom, $urandom});
      end else if (pick < 91) begin
        add_item(OP_SPARE, {$urandom, $urandom});
      end else if (pick < 96) begin
        add_item(OP_QUERY, {$urandom, $urandom});
      end else begin
        t_now = {1'b0, $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0, $urandom} ^
                {$urandom, $urandom} >> $urandom_range(1, 40);
        add_item(OP_PRESENT, t_now);
      end
    end
  endtask

  task automatic set_all(bit [31:0] nomv, bit [31:0] thr, bit [15:0] pg, bit [15:0] rg,
                         bit [15:0] tl, bit [15:0] wf, bit [26:0] fl);
    write_reg(CFG_RESYNC, thr);
    write_reg(CFG_PH_GAIN, {16'd0, pg});
    write_reg(CFG_PR_GAIN, {16'd0, rg});
    write_reg(CFG_TOL, {16'd0, tl});
    write_reg(CFG_WIN_FRAC, {16'd0, wf});
    write_reg(CFG_WIN_FLOOR, {5'd0, fl});
    write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_NOMINAL, nomv);
  endtask

  initial begin
    bit [63:0] t0;
    bit [31:0] nv;
    nom_ns = 64'(NOMINAL_RST);
    gap_limit_ns = 64'(RESYNC_RST);
    ph_gain = 64'(PH_GAIN_RST);
    pr_gain = 64'(PR_GAIN_RST);
    tol = 64'(TOL_RST);
    win_frac = 64'(WIN_FRAC_RST);
    win_floor = 64'(WIN_FLOOR_RST);
    restart_grid();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    run_go = 1'b1;

    // Directed: reset defaults, nothing to snap to, then lock up and break it.
    add_item(OP_QUERY, 64'd0);
    add_item(OP_QUERY, MAX63);
    add_item(OP_SPARE, 64'd12345);
    add_item(OP_PRESENT, 64'd1000);
    add_item(OP_PRESENT, 64'd1005);
    add_item(OP_PRESENT, 64'd500);
    t0 = 64'd1000;
    for (int i = 0; i < 10; i++) begin
      t0 = t0 + 64'd16666667 + $urandom_range(0, 200000) - 100000;
      add_item(OP_PRESENT, t0);
    end
    add_item(OP_QUERY, t0 + 64'd9000000);
    add_item(OP_QUERY, 64'd0);
    add_item(OP_PRESENT, t0 + 64'd40000000);
    add_item(OP_PRESENT, t0 + 64'd400000000);
    add_item(OP_PRESENT, t0 + 64'd400000000 + (64'd1 << 36));
    add_item(OP_RESET, MAX63);
    add_item(OP_PRESENT, MAX63);
    add_item(OP_QUERY, 64'd3);
    add_random_items(230, 64'd16666667);
    wait_drained();

    // Small period with a tight restart gap.
    set_all(32'd1000, 32'd20000, 16'd20000, 16'd3000, 16'd8000, 16'd6000, 27'd20);
    add_random_items(250, 64'd1000);
    wait_drained();

    // Gains, tolerance, window and restart gap at their top; large nominal and floor.
    set_all(32'd1000000000, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            27'd100000000);
    add_random_items(200, 64'd1000000000);
    wait_drained();

    // All registers at their bottom but a nominal of one, then tracking switched off.
    set_all(32'd1, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 27'd0);
    add_random_items(150, 64'd1);
    wait_drained();
    set_all(32'd0, 32'd1000, 16'd100, 16'd100, 16'd100, 16'd100, 27'd5);
    add_random_items(80, 64'd700);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      nv = $urandom_range(50, 5000000);
      set_all(nv, $urandom_range(0, 7) == 0 ? $urandom : nv * $urandom_range(2, 12),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 20000)),
              16'($urandom_range(0, 20000)), 16'($urandom_range(0, 20000)),
              27'($urandom_range(0, nv / 8)));
      if (ph == 3) no_idle = 1'b1;
      add_random_items(220, 64'(nv));
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/vplt_pkg.sv
hw/rtl/vplt_div.sv
hw/rtl/vplt_dp.sv
hw/rtl/vplt_ctrl.sv
hw/rtl/vsync_phase_lock_tracker_top.sv
tb/tb_top.sv
